// ----- rtl/kdsc_pkg.sv -----
// ----------------------------------------------------------------------------
// kdsc_pkg
// Shared widths, limits and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kdsc_pkg;

  localparam int TARGET_W = 11;
  localparam int VALUE_W  = 10;
  localparam int HERE_W   = 11;
  localparam int TOTAL_W  = 20;

  localparam logic [HERE_W-1:0]  HERE_MAX  = 11'h7FF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

  // controller -> datapath
  typedef struct packed {
    logic init_step;   // zero one table entry of the power-up sweep
    logic capture;     // load request, first half of the value reduction
    logic reduce;      // second half of the value reduction
    logic enter;       // push value into ring, read both occurrence entries
    logic mark_ovf;    // sequence already full: flag overflow, zero count
    logic add;         // bump occurrence counts and distinct counters
    logic ring_rd;     // read ring at the selected window's left pointer
    logic fetch;       // read occurrence entries of the leaving value
    logic drop;        // retire leaving value from the selected window
    logic next_win;    // switch from wide to narrow window
    logic sum;         // form count and update running total
    logic emit;        // load the result register
    logic clr_start;   // start of end-of-sequence cleanup
    logic clr_rd;      // cleanup: read ring entry
    logic clr_wr;      // cleanup: zero table entries of that value
    logic seq_reset;   // cleanup done: zero pointers and counters
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;
    logic full;
    logic need_shrink;
    logic win_narrow;
    logic last;
    logic clr_more;
  } dp_status_t;

endpackage

// ----- rtl/kdsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// kdsc_ctrl
// Sequencer for table init, request intake, window shrinking, result hand-off, cleanup.
// ----------------------------------------------------------------------------
module kdsc_ctrl
  import kdsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_REDUCE,
    S_ENTER,
    S_ADD,
    S_CHECK,
    S_FETCH,
    S_DROP,
    S_EMIT,
    S_CLR,
    S_CLR_WR
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.reduce = 1'b1;
        state_d      = S_ENTER;
      end
      S_ENTER: begin
        if (status_i.full) begin
          cmd_o.mark_ovf = 1'b1;
          state_d        = S_EMIT;
        end else begin
          cmd_o.enter = 1'b1;
          state_d     = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        priority if (status_i.need_shrink) begin
          cmd_o.ring_rd = 1'b1;
          state_d       = S_FETCH;
        end else if (!status_i.win_narrow) begin
          cmd_o.next_win = 1'b1;
        end else begin
          cmd_o.sum = 1'b1;
          state_d   = S_EMIT;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_DROP;
      end
      S_DROP: begin
        cmd_o.drop = 1'b1;
        state_d    = S_CHECK;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            cmd_o.clr_start = 1'b1;
            state_d         = S_CLR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CLR: begin
        if (status_i.clr_more) begin
          cmd_o.clr_rd = 1'b1;
          state_d      = S_CLR_WR;
        end else begin
          cmd_o.seq_reset = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_CLR_WR: begin
        cmd_o.clr_wr = 1'b1;
        state_d      = S_CLR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit)       out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/kdsc_datapath.sv -----
// ----------------------------------------------------------------------------
// kdsc_datapath
// Value ring, two occurrence tables, window pointers, counters, result regs.
// ----------------------------------------------------------------------------
module kdsc_datapath
  import kdsc_pkg::*;
#(
  parameter int MAX_LEN     = 1024,
  parameter int VALUE_RANGE = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TARGET_W-1:0] cfg_wdata_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic                last_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output logic [HERE_W-1:0]   ending_here_o,
  output logic [TOTAL_W-1:0]  running_total_o,
  output logic                final_item_o,
  output logic                overflow_o
);

  localparam int PW   = $clog2(MAX_LEN + 1);
  localparam int RW   = $clog2(MAX_LEN);
  localparam int IW   = $clog2(VALUE_RANGE);
  localparam int CMPW = (PW > TARGET_W) ? PW : TARGET_W;

  // restoring reduction by VALUE_RANGE, five shifted subtract steps per call
  function automatic logic [VALUE_W-1:0] mod_steps(input logic [VALUE_W-1:0] x,
                                                   input int base);
    logic [31:0]        step;
    logic [VALUE_W-1:0] r;
    r = x;
    for (int k = 4; k >= 0; k--) begin
      step = 32'(VALUE_RANGE) << (k + base);
      if (32'(r) >= step) r = r - VALUE_W'(step);
    end
    return r;
  endfunction

  // storage
  logic [IW-1:0] ring_mem  [MAX_LEN];
  logic [PW-1:0] occ_w_mem [VALUE_RANGE];
  logic [PW-1:0] occ_n_mem [VALUE_RANGE];

  logic [IW-1:0] ring_rd_q;
  logic [PW-1:0] occ_w_rd_q, occ_n_rd_q;

  // state
  logic [TARGET_W-1:0] target_q;
  logic [PW-1:0]       pos_q, left_w_q, left_n_q, dist_w_q, dist_n_q, clr_idx_q;
  logic [TOTAL_W-1:0]  total_q;
  logic                ovf_q, sel_q;
  logic [IW-1:0]       init_idx_q;
  logic [VALUE_W-1:0]  v_q;
  logic                last_q;
  logic [HERE_W-1:0]   here_q;

  logic [HERE_W-1:0]  here_out_q;
  logic [TOTAL_W-1:0] total_out_q;
  logic               final_out_q, ovf_out_q;

  // derived
  logic [IW-1:0]       v_idx;
  logic [TARGET_W-1:0] lim_w, lim_n, lim_sel;
  logic [PW-1:0]       dist_sel, left_sel, occ_sel_rd, diff, left_min;
  logic [HERE_W-1:0]   here_sat;
  logic [TOTAL_W:0]    total_sum;
  logic [TOTAL_W-1:0]  total_next;

  assign v_idx    = IW'(v_q);
  assign lim_w    = target_q;
  assign lim_n    = (target_q != '0) ? target_q - 1'b1 : '0;
  assign lim_sel  = sel_q ? lim_n : lim_w;
  assign dist_sel = sel_q ? dist_n_q : dist_w_q;
  assign left_sel = sel_q ? left_n_q : left_w_q;
  assign occ_sel_rd = sel_q ? occ_n_rd_q : occ_w_rd_q;
  assign left_min = (left_w_q < left_n_q) ? left_w_q : left_n_q;

  assign diff     = (left_n_q >= left_w_q) ? left_n_q - left_w_q : '0;
  assign here_sat = (CMPW'(diff) > CMPW'(HERE_MAX)) ? HERE_MAX : HERE_W'(diff);
  assign total_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(here_sat);
  assign total_next = (total_sum > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                               : total_sum[TOTAL_W-1:0];

  assign status_o.init_last   = (init_idx_q == IW'(VALUE_RANGE - 1));
  assign status_o.full        = (pos_q == PW'(MAX_LEN));
  assign status_o.need_shrink = (CMPW'(dist_sel) > CMPW'(lim_sel)) && (left_sel < pos_q);
  assign status_o.win_narrow  = sel_q;
  assign status_o.last        = last_q;
  assign status_o.clr_more    = (clr_idx_q < pos_q);

  // ring port
  logic          ring_re;
  logic [RW-1:0] ring_raddr;
  assign ring_re    = cmd_i.ring_rd || cmd_i.clr_rd;
  assign ring_raddr = cmd_i.ring_rd ? left_sel[RW-1:0] : clr_idx_q[RW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.enter) ring_mem[pos_q[RW-1:0]] <= v_idx;
    if (ring_re)     ring_rd_q <= ring_mem[ring_raddr];
  end

  // occurrence table ports
  logic          occ_re;
  logic [IW-1:0] occ_raddr;
  logic          ow_we, on_we;
  logic [IW-1:0] occ_waddr;
  logic [PW-1:0] ow_wdata, on_wdata;

  assign occ_re    = cmd_i.enter || cmd_i.fetch;
  assign occ_raddr = cmd_i.enter ? v_idx : ring_rd_q;

  always_comb begin
    ow_we     = 1'b0;
    on_we     = 1'b0;
    occ_waddr = ring_rd_q;
    ow_wdata  = '0;
    on_wdata  = '0;
    priority if (cmd_i.init_step) begin
      ow_we     = 1'b1;
      on_we     = 1'b1;
      occ_waddr = init_idx_q;
    end else if (cmd_i.add) begin
      ow_we     = 1'b1;
      on_we     = 1'b1;
      occ_waddr = v_idx;
      ow_wdata  = occ_w_rd_q + 1'b1;
      on_wdata  = occ_n_rd_q + 1'b1;
    end else if (cmd_i.drop) begin
      ow_we    = !sel_q && (occ_sel_rd != '0);
      on_we    = sel_q && (occ_sel_rd != '0);
      ow_wdata = occ_sel_rd - 1'b1;
      on_wdata = occ_sel_rd - 1'b1;
    end else if (cmd_i.clr_wr) begin
      ow_we = 1'b1;
      on_we = 1'b1;
    end else begin
      ow_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ow_we)  occ_w_mem[occ_waddr] <= ow_wdata;
    if (occ_re) occ_w_rd_q <= occ_w_mem[occ_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (on_we)  occ_n_mem[occ_waddr] <= on_wdata;
    if (occ_re) occ_n_rd_q <= occ_n_mem[occ_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_W'(1);
      pos_q      <= '0;
      left_w_q   <= '0;
      left_n_q   <= '0;
      dist_w_q   <= '0;
      dist_n_q   <= '0;
      total_q    <= '0;
      ovf_q      <= 1'b0;
      sel_q      <= 1'b0;
      init_idx_q <= '0;
      clr_idx_q  <= '0;
    end else begin
      if (cfg_we_i)        target_q   <= cfg_wdata_i;
      if (cmd_i.init_step) init_idx_q <= init_idx_q + 1'b1;
      if (cmd_i.enter)     pos_q      <= pos_q + 1'b1;
      if (cmd_i.mark_ovf)  ovf_q      <= 1'b1;
      if (cmd_i.add) begin
        sel_q <= 1'b0;
        if (occ_w_rd_q == '0) dist_w_q <= dist_w_q + 1'b1;
        if (occ_n_rd_q == '0) dist_n_q <= dist_n_q + 1'b1;
      end
      if (cmd_i.next_win) sel_q <= 1'b1;
      if (cmd_i.drop) begin
        if (sel_q) begin
          left_n_q <= left_n_q + 1'b1;
          if (occ_n_rd_q == PW'(1) && dist_n_q != '0) dist_n_q <= dist_n_q - 1'b1;
        end else begin
          left_w_q <= left_w_q + 1'b1;
          if (occ_w_rd_q == PW'(1) && dist_w_q != '0) dist_w_q <= dist_w_q - 1'b1;
        end
      end
      if (cmd_i.sum)       total_q   <= total_next;
      if (cmd_i.clr_start) clr_idx_q <= left_min;
      if (cmd_i.clr_wr)    clr_idx_q <= clr_idx_q + 1'b1;
      if (cmd_i.seq_reset) begin
        pos_q    <= '0;
        left_w_q <= '0;
        left_n_q <= '0;
        dist_w_q <= '0;
        dist_n_q <= '0;
        total_q  <= '0;
        ovf_q    <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      v_q    <= mod_steps(value_i, 5);
      last_q <= last_i;
    end
    if (cmd_i.reduce)   v_q    <= mod_steps(v_q, 0);
    if (cmd_i.mark_ovf) here_q <= '0;
    if (cmd_i.sum)      here_q <= here_sat;
    if (cmd_i.emit) begin
      here_out_q  <= here_q;
      total_out_q <= total_q;
      final_out_q <= last_q;
      ovf_out_q   <= ovf_q;
    end
  end

  assign ending_here_o   = here_out_q;
  assign running_total_o = total_out_q;
  assign final_item_o    = final_out_q;
  assign overflow_o      = ovf_out_q;

endmodule

// ----- rtl/k_distinct_subarray_counter_top.sv -----
// ----------------------------------------------------------------------------
// k_distinct_subarray_counter_top
// Counts subarrays with exactly K distinct values ending at each element.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request per element:
//   value_i plus last_i on the final element of a sequence. Output channel
//   (out_valid_o/out_ready_i) returns one result per request: ending_here_o,
//   running_total_o (saturating), final_item_o and the sticky overflow_o.
//   cfg_we_i/cfg_wdata_i write K (distinct_target) while the block is idle.
// Timing:
//   One request at a time. A request passes the states REDUCE, ENTER, ADD
//   and CHECK (once for each window) to EMIT, which loads the result
//   register; once the sequence is past the ring, ENTER goes straight to
//   EMIT. Every element that leaves either window adds a ring read, FETCH
//   and DROP (each element leaves each window at most once). The shrink
//   loop is bound by the single read port on the ring and on each
//   occurrence table. After a last request, cleanup walks the live window,
//   reading each ring entry and then zeroing its table entries.
// Reset:
//   rst_ni clears all control state, then a sweep zeroes both occurrence
//   tables entry by entry; in_ready_o stays low until it finishes.
// Stall:
//   A result waits in the output register; the next request is still taken
//   and worked on, and only its hand-off waits for the register to free up.
// ----------------------------------------------------------------------------
module k_distinct_subarray_counter_top
  import kdsc_pkg::*;
#(
  parameter int MAX_LEN     = 1024,
  parameter int VALUE_RANGE = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TARGET_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HERE_W-1:0]   ending_here_o,
  output logic [TOTAL_W-1:0]  running_total_o,
  output logic                final_item_o,
  output logic                overflow_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: intake, per-window shrink loop, hand-off, cleanup
  kdsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // ring, occurrence tables, pointers and result register
  kdsc_datapath #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_RANGE (VALUE_RANGE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .value_i         (value_i),
    .last_i          (last_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .ending_here_o   (ending_here_o),
    .running_total_o (running_total_o),
    .final_item_o    (final_item_o),
    .overflow_o      (overflow_o)
  );

endmodule
